>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the selector.
// Stands alone; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, switched off while reset is asserted.
`define TKS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tks assertion failed");

// Implication into the following cycle, switched off while reset is asserted.
`define TKS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tks assertion failed");

// Implication into the following cycle that also holds through reset.
`define TKS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tks assertion failed");

`endif

>>> rtl/core/tks_pkg.sv
// Shared types, codes and defaults for the top-k smallest selector.
// No dependencies; every other file of the selector but assert_macros.svh uses it.
package tks_pkg;

    // Default sizes of the design.
    localparam int MAX_KEEP_DEF   = 64;
    localparam int VALUE_BITS_DEF = 30;

    // Keep count register.
    localparam int         KEEP_BITS  = 7;
    localparam logic [6:0] KEEP_RESET = 7'd64;

    // Configuration port layout: one 32-bit register per word.
    localparam int         ADDR_BITS      = 3;
    localparam logic [0:0] REG_KEEP_COUNT = 1'b0;

    // Input commands.
    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;    // insert the offered value in sorted position
        logic grow;   // insertion adds an entry rather than replacing the largest
        logic shift;  // move every entry one cell towards the head
    } tks_ctrl_t;

endpackage

>>> rtl/core/tks_cell.sv
// One cell of the sorted chain: holds a single kept value and its valid flag.
// Depends on tks_pkg for the control struct.
module tks_cell #(
    parameter int VALUE_BITS = tks_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tks_pkg::tks_ctrl_t    ctrl,
    input  logic [VALUE_BITS-1:0] ins_value,
    input  logic [VALUE_BITS-1:0] left_val,
    input  logic                  left_valid,
    input  logic                  left_lt,
    input  logic [VALUE_BITS-1:0] right_val,
    input  logic                  right_valid,
    output logic [VALUE_BITS-1:0] val,
    output logic                  valid,
    output logic                  lt
);

    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    logic                  valid_reg;
    logic                  valid_next;

    // The offered value belongs in front of this entry.
    assign lt    = valid_reg && (ins_value < val_reg);
    assign val   = val_reg;
    assign valid = valid_reg;

    // Insertion pushes larger entries one cell to the right; a drain shifts left.
    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            val_next   = right_val;
            valid_next = right_valid;
        end else if (ctrl.ins) begin
            if (left_lt) begin
                val_next = left_val;
            end else if (lt || !valid_reg) begin
                val_next = ins_value;
            end
            if (ctrl.grow) begin
                valid_next = valid_reg | left_valid;
            end
        end
    end

    // The valid flag is control state; the value needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

>>> rtl/core/top_k_smallest_selector.sv
// Top level of the top-k smallest selector: stream ports, APB register, control.
// Depends on tks_pkg and instantiates a chain of tks_cell.
//
// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       s_tdata = value, s_tuser = command
// m_        out        m_tvalid / m_tready       m_tdata = kept_value, m_tlast, m_tuser
// apb       in         psel, penable, pready     paddr, pwdata, prdata (keep_count)
//
// On an offer every cell compares and shifts in parallel; the next item can follow without a wait.
// A drain of n kept values is accepted into the drain state, then gives one result per cycle
// while m_tready is high, as the chain shifts towards the head cell.
// A drain of an empty store goes through the empty state, which loads its single result into the output register.
// Reset (aresetn low, synchronous) empties the chain and sets keep_count to 64.
// A stalled result holds in the output register; offers are still taken then unless a drain is under way.
module top_k_smallest_selector #(
    parameter int MAX_KEEP   = tks_pkg::MAX_KEEP_DEF,
    parameter int VALUE_BITS = tks_pkg::VALUE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]    s_tdata,   // [VALUE_BITS-1:0] value
    input  logic                               s_tuser,   // [0] command
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((VALUE_BITS+7)/8)*8-1:0]    m_tdata,   // [VALUE_BITS-1:0] kept_value
    output logic                               m_tlast,
    output logic                               m_tuser,   // [0] empty_res
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tks_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CNT_BITS  = $clog2(MAX_KEEP + 1);
    localparam int CMP_BITS  = (CNT_BITS > tks_pkg::KEEP_BITS) ? CNT_BITS : tks_pkg::KEEP_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [tks_pkg::KEEP_BITS-1:0] keep_count_reg;
    logic [tks_pkg::KEEP_BITS-1:0] keep_count_next;
    logic [CNT_BITS-1:0]          kept_total_reg;
    logic [CNT_BITS-1:0]          kept_total_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [VALUE_BITS-1:0]        out_value_reg;
    logic [VALUE_BITS-1:0]        out_value_next;
    logic                         out_last_reg;
    logic                         out_last_next;
    logic                         out_empty_reg;
    logic                         out_empty_next;

    logic                         in_xfer;
    logic                         slot_free;
    logic                         cfg_wr;
    logic                         reg_hit;
    logic [CMP_BITS-1:0]          keep_eff;
    logic [CMP_BITS-1:0]          keep_ext;
    logic                         grow;
    tks_pkg::tks_ctrl_t           ctrl;
    logic [VALUE_BITS-1:0]        in_value;

    logic [VALUE_BITS-1:0]        cell_val   [0:MAX_KEEP];
    logic                         cell_valid [0:MAX_KEEP];
    logic                         cell_lt    [0:MAX_KEEP-1];

    // Handshakes.
    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || m_tready;
    assign in_value  = s_tdata[VALUE_BITS-1:0];

    // Configuration register access.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[tks_pkg::ADDR_BITS-1:2] == tks_pkg::REG_KEEP_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_hit ? 32'(keep_count_reg) : 32'd0;

    always_comb begin
        keep_count_next = keep_count_reg;
        if (cfg_wr && reg_hit) begin
            keep_count_next = pwdata[tks_pkg::KEEP_BITS-1:0];
        end
    end

    // Effective keep count, clamped to one and to the chain length.
    always_comb begin
        keep_ext = CMP_BITS'(keep_count_reg);
        keep_eff = keep_ext;
        if (keep_ext == '0) begin
            keep_eff = CMP_BITS'(1);
        end else if (keep_ext > CMP_BITS'(MAX_KEEP)) begin
            keep_eff = CMP_BITS'(MAX_KEEP);
        end
    end

    assign grow = (CMP_BITS'(kept_total_reg) < keep_eff);

    // Chain operation for this cycle.
    always_comb begin
        ctrl.ins   = in_xfer && (s_tuser == tks_pkg::CMD_OFFER);
        ctrl.grow  = grow;
        ctrl.shift = (state_reg == ST_DRAIN) && slot_free;
    end

    // Sequencing of drains and the output register.
    always_comb begin
        state_next      = state_reg;
        kept_total_next = kept_total_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == tks_pkg::CMD_DRAIN) begin
                        kept_total_next = '0;
                        state_next      = cell_valid[0] ? ST_DRAIN : ST_EMPTY;
                    end else if (grow) begin
                        kept_total_next = kept_total_reg + CNT_BITS'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_value_next = cell_val[0];
                    out_last_next  = !cell_valid[1];
                    out_empty_next = 1'b0;
                    if (!cell_valid[1]) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMPTY: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            keep_count_reg <= tks_pkg::KEEP_RESET;
            kept_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            keep_count_reg <= keep_count_next;
            kept_total_reg <= kept_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_BITS'(out_value_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    // Sorted chain: the head cell holds the smallest kept value.
    assign cell_val[MAX_KEEP]   = '0;
    assign cell_valid[MAX_KEEP] = 1'b0;

    for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
        logic [VALUE_BITS-1:0] left_val;
        logic                  left_valid;
        logic                  left_lt;
        if (i == 0) begin : g_head
            assign left_val   = '0;
            assign left_valid = 1'b1;
            assign left_lt    = 1'b0;
        end else begin : g_body
            assign left_val   = cell_val[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_lt    = cell_lt[i-1];
        end
        tks_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .ins_value   (in_value),
            .left_val    (left_val),
            .left_valid  (left_valid),
            .left_lt     (left_lt),
            .right_val   (cell_val[i+1]),
            .right_valid (cell_valid[i+1]),
            .val         (cell_val[i]),
            .valid       (cell_valid[i]),
            .lt          (cell_lt[i])
        );
    end

endmodule

>>> rtl/core/tks_checker.sv
// Port-level checks for the top-k smallest selector, bound to the top level.
// Depends on assert_macros.svh and tks_pkg.
`include "assert_macros.svh"

module tks_checker #(
    parameter int VALUE_BITS = tks_pkg::VALUE_BITS_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata,
    input logic                            m_tlast,
    input logic                            m_tuser
);

    // Whole result payload, so that it can be checked as one word.
    logic [((VALUE_BITS+7)/8)*8+1:0] m_pay;

    assign m_pay = {m_tdata, m_tlast, m_tuser};

    // No result is offered in the cycle after reset.
    `TKS_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid)

    // A stalled result transfer keeps its payload.
    `TKS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_pay))

    // An empty drain gives a single zero result that closes the run.
    `TKS_ASSERT_SAME(a_empty_form, aclk, aresetn, m_tvalid && m_tuser, m_tlast && (m_tdata == '0))

    // While a drain run is still open no new item is taken.
    `TKS_ASSERT_SAME(a_drain_blocks, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)

endmodule

bind top_k_smallest_selector tks_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_tks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

>>> bench/top_k_smallest_selector_tb.sv
// Self-checking bench for the top-k smallest selector: random and directed offers and drains.
// Depends on tks_pkg and the top_k_smallest_selector RTL; a scoreboard class predicts each drain.
`timescale 1ns / 1ps

module top_k_smallest_selector_tb;

    localparam int MAX_KEEP      = tks_pkg::MAX_KEEP_DEF;
    localparam int VALUE_BITS    = tks_pkg::VALUE_BITS_DEF;
    localparam int KEEP_BITS     = tks_pkg::KEEP_BITS;
    localparam int ADDR_BITS     = tks_pkg::ADDR_BITS;
    localparam int DATA_BITS     = ((VALUE_BITS + 7) / 8) * 8;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int ITEM_TARGET   = 350;
    localparam int DRAIN_LIMIT   = 100000;
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
    localparam logic [ADDR_BITS-1:0]  KEEP_ADDR = {tks_pkg::REG_KEEP_COUNT, 2'b00};

    // One expected result of a drain.
    typedef struct packed {
        logic [VALUE_BITS-1:0] kept_value;
        logic                  last;
        logic                  empty_res;
    } kept_result_t;

    // Scoreboard: holds its own copy of the kept store and the queue of expected results.
    class kept_value_board;
        bit [KEEP_BITS-1:0]  keep_count;
        bit [VALUE_BITS-1:0] held[MAX_KEEP];
        int unsigned         held_total;
        bit [VALUE_BITS-1:0] held_max;
        kept_result_t        due[$];
        int unsigned         faults;

        function new();
            keep_count = tks_pkg::KEEP_RESET;
            held_total = 0;
            held_max   = '0;
            faults     = 0;
        endfunction

        function int outstanding();
            return due.size();
        endfunction

        task report(input string what);
            $display("ERROR at %0t ns: %s", $time, what);
            faults++;
        endtask

        // Append one expectation to the back of the queue.
        function void queue_due(input kept_result_t r);
            due = {due, r};
        endfunction

        // Offer one value to the store; a keep count of zero behaves as one.
        function void offer_value(input bit [VALUE_BITS-1:0] v);
            int unsigned limit;
            bit          swapped;
            limit = keep_count;
            if (limit < 1) limit = 1;
            if (limit > MAX_KEEP) limit = MAX_KEEP;
            if (held_total < limit) begin
                held[held_total] = v;
                if (held_total == 0 || v > held_max) held_max = v;
                held_total++;
            end else if (v < held_max) begin
                // Replace one copy of the largest value, then find the largest again.
                swapped = 1'b0;
                for (int i = 0; i < held_total; i++) begin
                    if (!swapped && held[i] == held_max) begin
                        held[i] = v;
                        swapped = 1'b1;
                    end
                end
                held_max = '0;
                for (int i = 0; i < held_total; i++)
                    if (held[i] > held_max) held_max = held[i];
            end
        endfunction

        // Sort the kept values and queue them as the results of one drain.
        function void drain_store();
            bit [VALUE_BITS-1:0] order[MAX_KEEP];
            bit [VALUE_BITS-1:0] x;
            kept_result_t        res;
            int                  j;
            if (held_total == 0) begin
                res.kept_value = '0;
                res.last       = 1'b1;
                res.empty_res  = 1'b1;
                queue_due(res);
            end else begin
                for (int i = 0; i < held_total; i++) begin
                    x = held[i];
                    j = i;
                    while (j > 0 && order[j-1] > x) begin
                        order[j] = order[j-1];
                        j--;
                    end
                    order[j] = x;
                end
                for (int i = 0; i < held_total; i++) begin
                    res.kept_value = order[i];
                    res.last       = (i + 1 == held_total);
                    res.empty_res  = 1'b0;
                    queue_due(res);
                end
            end
            held_total = 0;
            held_max   = '0;
        endfunction

        // Note one accepted input transfer.
        function void note_transfer(input logic cmd, input logic [VALUE_BITS-1:0] v);
            if (cmd == tks_pkg::CMD_OFFER) offer_value(v);
            else drain_store();
        endfunction

        // Compare one accepted result transfer with the oldest expectation.
        task check_transfer(input logic [VALUE_BITS-1:0] v, input logic last,
                            input logic empty_res);
            kept_result_t want;
            if (due.size() == 0) begin
                report($sformatf("unexpected result value=%0d last=%b empty=%b",
                                 v, last, empty_res));
            end else begin
                want = due.pop_front();
                if (v !== want.kept_value)
                    report($sformatf("kept_value %0d, expected %0d", v, want.kept_value));
                if (last !== want.last)
                    report($sformatf("last %b, expected %b", last, want.last));
                if (empty_res !== want.empty_res)
                    report($sformatf("empty_res %b, expected %b", empty_res, want.empty_res));
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_BITS-1:0]  s_tdata;   // [VALUE_BITS-1:0] value
    logic                  s_tuser;   // [0] command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_BITS-1:0]  m_tdata;   // [VALUE_BITS-1:0] kept_value
    logic                  m_tlast;
    logic                  m_tuser;   // [0] empty_res
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_BITS-1:0]  paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    kept_value_board board;
    bit              no_idle;
    bit              hold_req;
    bit              hold_taken;
    int unsigned     items_sent;

    top_k_smallest_selector #(
        .MAX_KEEP   (MAX_KEEP),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock.
    always begin
        aclk = 1'b0;
        #(HALF_PERIOD);
        aclk = 1'b1;
        #(HALF_PERIOD);
    end

    // Result side: random back-pressure, or one long hold-off when asked for.
    initial begin
        m_tready   = 1'b0;
        hold_taken = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready   = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready = no_idle || ($urandom_range(99) >= 28);
            end
        end
    end

    // Every accepted result transfer goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_transfer(m_tdata[VALUE_BITS-1:0], m_tlast, m_tuser);
    end

    // Hard limit on the length of the run.
    initial begin
        #(TIMEOUT_NS);
        $display("top_k_smallest_selector: mismatch");
        $finish;
    end

    // Random value, weighted towards repeats and the ends of the range.
    function automatic logic [VALUE_BITS-1:0] rand_value();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return raw[VALUE_BITS-1:0];
            5, 6:          return VALUE_BITS'($urandom_range(15));
            7:             return '0;
            8:             return VALUE_MAX;
            default:       return VALUE_MAX - VALUE_BITS'($urandom_range(7));
        endcase
    endfunction

    // Present one item and wait for its transfer; leaves tvalid high at a falling edge.
    task automatic send_item(input logic cmd, input logic [VALUE_BITS-1:0] val);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 28) gap = $urandom_range(1, 6);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = '0;
        s_tdata[VALUE_BITS-1:0] = val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_transfer(cmd, val);
        items_sent++;
        @(negedge aclk);
    endtask

    // Stop sending, wait for every expected result, then allow the last offer to finish.
    task automatic settle();
        s_tvalid = 1'b0;
        while (board.outstanding() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write the keep count register once the block is idle.
    task automatic write_keep(input logic [KEEP_BITS-1:0] val);
        settle();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = KEEP_ADDR;
        pwdata  = 32'(val);
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        board.keep_count = val;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Main sequence: reset, directed cases, a long hold-off, then random phases.
    initial begin : stimulus
        int unsigned phase;
        int unsigned runs;
        int unsigned fill;
        int unsigned pick;
        int unsigned guard;
        logic [KEEP_BITS-1:0] keep;

        board      = new();
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = tks_pkg::CMD_OFFER;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Drain of an empty store, then extremes and repeated values at the reset keep count.
        send_item(tks_pkg::CMD_DRAIN, VALUE_MAX);
        send_item(tks_pkg::CMD_OFFER, '0);
        send_item(tks_pkg::CMD_OFFER, VALUE_MAX);
        send_item(tks_pkg::CMD_OFFER, 30'h2AAAAAAA);
        send_item(tks_pkg::CMD_OFFER, 30'h15555555);
        send_item(tks_pkg::CMD_OFFER, VALUE_MAX);
        send_item(tks_pkg::CMD_OFFER, '0);
        send_item(tks_pkg::CMD_DRAIN, 30'h15555555);

        // Keep only one: a smaller value replaces, an equal or larger one does not.
        write_keep(7'd1);
        send_item(tks_pkg::CMD_OFFER, 30'd5);
        send_item(tks_pkg::CMD_OFFER, 30'd3);
        send_item(tks_pkg::CMD_OFFER, 30'd3);
        send_item(tks_pkg::CMD_OFFER, 30'd9);
        send_item(tks_pkg::CMD_DRAIN, '0);

        // Lowering the keep count below the present total drops no entry.
        write_keep(7'd3);
        send_item(tks_pkg::CMD_OFFER, 30'd40);
        send_item(tks_pkg::CMD_OFFER, 30'd10);
        send_item(tks_pkg::CMD_OFFER, 30'd25);
        write_keep(7'd1);
        send_item(tks_pkg::CMD_OFFER, 30'd30);
        send_item(tks_pkg::CMD_OFFER, 30'd2);
        send_item(tks_pkg::CMD_DRAIN, '0);

        // A keep count of zero behaves as one.
        write_keep(7'd0);
        send_item(tks_pkg::CMD_OFFER, 30'd8);
        send_item(tks_pkg::CMD_OFFER, 30'd8);
        send_item(tks_pkg::CMD_OFFER, 30'd7);
        send_item(tks_pkg::CMD_DRAIN, '0);

        // Hold the result side off while offers and drains keep arriving.
        write_keep(7'd64);
        hold_req = 1'b1;
        repeat (30) send_item(tks_pkg::CMD_OFFER, rand_value());
        send_item(tks_pkg::CMD_DRAIN, '0);
        repeat (5) send_item(tks_pkg::CMD_OFFER, rand_value());
        send_item(tks_pkg::CMD_DRAIN, '0);
        send_item(tks_pkg::CMD_DRAIN, '0);
        settle();

        // Random phases, each at its own keep count.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase % 7)
                0:       keep = 7'd127;
                1:       keep = 7'd64;
                2:       keep = 7'd2;
                3:       keep = 7'd0;
                4:       keep = 7'd1;
                5:       keep = KEEP_BITS'($urandom_range(3, 63));
                default: keep = KEEP_BITS'($urandom_range(65, 126));
            endcase
            write_keep(keep);
            no_idle = (phase == 1);
            runs = $urandom_range(1, 4);
            repeat (runs) begin
                pick = $urandom_range(99);
                if (no_idle) fill = $urandom_range(40, 90);
                else if (pick < 8) fill = 0;
                else if (pick < 20) fill = $urandom_range(40, 90);
                else fill = $urandom_range(1, 12);
                repeat (fill) send_item(tks_pkg::CMD_OFFER, rand_value());
                // Now and then the keep count moves while values are held.
                if ($urandom_range(99) < 15) begin
                    write_keep(KEEP_BITS'($urandom_range(0, 127)));
                    repeat ($urandom_range(1, 8)) send_item(tks_pkg::CMD_OFFER, rand_value());
                end
                send_item(tks_pkg::CMD_DRAIN, rand_value());
                if ($urandom_range(99) < 10) send_item(tks_pkg::CMD_DRAIN, rand_value());
            end
            phase++;
        end
        no_idle = 1'b0;

        // Let the last results arrive, then give the block time to show anything extra.
        s_tvalid = 1'b0;
        guard = 0;
        while (board.outstanding() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (board.outstanding() != 0)
            board.report($sformatf("%0d expected results never arrived", board.outstanding()));
        if (board.faults == 0) begin
            $display("top_k_smallest_selector: match");
        end else begin
            $display("top_k_smallest_selector: mismatch");
        end
        $finish;
    end

endmodule
